FILE: rtl/cfd_pkg.sv
// Shared types, opcode constants and decode records for the control-flow decoder.
package cfd_pkg;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_RTS  = 3'd1,
    KIND_JMP  = 3'd2,
    KIND_JSR  = 3'd3,
    KIND_BSR  = 3'd4,
    KIND_BRA  = 3'd5,
    KIND_BCC  = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    MODE_NONE   = 3'd0,
    MODE_AN     = 3'd1,
    MODE_D16AN  = 3'd2,
    MODE_PCD16  = 3'd3,
    MODE_D8ANXN = 3'd4,
    MODE_PCD8XN = 3'd5,
    MODE_ABSW   = 3'd6,
    MODE_ABSL   = 3'd7
  } mode_e;

  // Source of the displacement field.
  typedef enum logic [1:0] {
    DISP_ZERO   = 2'd0,
    DISP_SEXT8  = 2'd1,
    DISP_SEXT16 = 2'd2,
    DISP_ABS32  = 2'd3
  } disp_sel_e;

  localparam logic [15:0] OP_RTS       = 16'h4e75;
  localparam logic [15:0] OP_REG_MASK  = 16'hfff8;
  localparam logic [15:0] OP_JSR_AN    = 16'h4e90;
  localparam logic [15:0] OP_JMP_AN    = 16'h4ed0;
  localparam logic [15:0] OP_JSR_D16   = 16'h4ea8;
  localparam logic [15:0] OP_JMP_D16   = 16'h4ee8;
  localparam logic [15:0] OP_JSR_PCD16 = 16'h4eba;
  localparam logic [15:0] OP_JMP_PCD16 = 16'h4efa;
  localparam logic [15:0] OP_JSR_IDX   = 16'h4eb0;
  localparam logic [15:0] OP_JMP_IDX   = 16'h4ef0;
  localparam logic [15:0] OP_JSR_PCIDX = 16'h4ebb;
  localparam logic [15:0] OP_JMP_PCIDX = 16'h4efb;
  localparam logic [15:0] OP_JSR_ABSW  = 16'h4eb8;
  localparam logic [15:0] OP_JMP_ABSW  = 16'h4ef8;
  localparam logic [15:0] OP_JSR_ABSL  = 16'h4eb9;
  localparam logic [15:0] OP_JMP_ABSL  = 16'h4ef9;
  localparam logic [3:0]  OP_BRANCH_HI = 4'h6;
  localparam logic [3:0]  COND_BSR     = 4'h1;
  localparam logic [3:0]  COND_ALWAYS  = 4'h0;

  // Opcode class found in the first stage.
  typedef struct packed {
    kind_e       kind;
    mode_e       mode;
    logic [2:0]  addr_reg;
    logic [3:0]  cond;
    logic [2:0]  len;
    logic [1:0]  adv;
    logic        idx;
    logic [1:0]  need;
    disp_sel_e   sel;
    logic        sub_two;
  } class_t;

  // Result fields other than the displacement.
  typedef struct packed {
    kind_e       kind;
    mode_e       mode;
    logic [2:0]  addr_reg;
    logic [3:0]  cond;
    logic [2:0]  len;
    logic [1:0]  adv;
    logic        idx;
  } res_t;

endpackage

FILE: rtl/control_flow_instruction_decoder_unit.sv
// Input beats pass through the stage registers in order to the output at one beat
// per cycle while the output does not stall; every stage register advances when
// the next is empty or being emptied, so a stall at the output backs up without loss.
// Reset clears only the three stage valid bits; the data registers are not reset.
// The three stages are opcode classification, operand selection and branch offset.
module control_flow_instruction_decoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        opcode_word_i,
  input  logic [15:0]        ext_word_one_i,
  input  logic [15:0]        ext_word_two_i,
  input  logic [1:0]         words_available_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic [2:0]         ea_mode_o,
  output logic [2:0]         addr_reg_o,
  output logic signed [31:0] displacement_o,
  output logic [3:0]         cond_code_o,
  output logic [2:0]         length_bytes_o,
  output logic [1:0]         pc_advance_o,
  output logic               index_ext_follows_o
);

  logic              s1_valid, s1_ready;
  cfd_pkg::class_t   s1_cls;
  logic [7:0]        s1_imm8;
  logic [15:0]       s1_ext_one, s1_ext_two;
  logic [1:0]        s1_avail;
  logic              s2_valid, s2_ready;
  cfd_pkg::res_t     s2_res;
  logic [31:0]       s2_disp;
  logic              s2_sub_two;
  cfd_pkg::res_t     s3_res;
  logic [31:0]       s3_disp;

  cfd_classify u_classify (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_word_i     (opcode_word_i),
    .ext_word_one_i    (ext_word_one_i),
    .ext_word_two_i    (ext_word_two_i),
    .words_available_i (words_available_i),
    .out_valid_o       (s1_valid),
    .out_ready_i       (s1_ready),
    .cls_o             (s1_cls),
    .imm8_o            (s1_imm8),
    .ext_one_o         (s1_ext_one),
    .ext_two_o         (s1_ext_two),
    .avail_o           (s1_avail)
  );

  cfd_operand u_operand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .cls_i       (s1_cls),
    .imm8_i      (s1_imm8),
    .ext_one_i   (s1_ext_one),
    .ext_two_i   (s1_ext_two),
    .avail_i     (s1_avail),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .res_o       (s2_res),
    .disp_o      (s2_disp),
    .sub_two_o   (s2_sub_two)
  );

  cfd_adjust u_adjust (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .res_i       (s2_res),
    .disp_i      (s2_disp),
    .sub_two_i   (s2_sub_two),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (s3_res),
    .disp_o      (s3_disp)
  );

  assign kind_o              = s3_res.kind;
  assign ea_mode_o           = s3_res.mode;
  assign addr_reg_o          = s3_res.addr_reg;
  assign displacement_o      = s3_disp;
  assign cond_code_o         = s3_res.cond;
  assign length_bytes_o      = s3_res.len;
  assign pc_advance_o        = s3_res.adv;
  assign index_ext_follows_o = s3_res.idx;

`ifndef SYNTHESIS
  // An unrecognized beat carries nothing but zeros.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == cfd_pkg::KIND_NONE |->
      ea_mode_o == 3'd0 && addr_reg_o == 3'd0 && displacement_o == 32'sd0 &&
      cond_code_o == 4'd0 && length_bytes_o == 3'd0 && pc_advance_o == 2'd0 &&
      !index_ext_follows_o)
    else $error("unrecognized beat has nonzero fields");

  // Only word BRA and Bcc move the PC and only Bcc carries a condition.
  a_adv_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pc_advance_o != 2'd0 |->
      (kind_o == cfd_pkg::KIND_BRA || kind_o == cfd_pkg::KIND_BCC) &&
      length_bytes_o == 3'd4)
    else $error("pc advance on a non-branch beat");

  a_cond_bcc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cond_code_o != 4'd0 |-> kind_o == cfd_pkg::KIND_BCC)
    else $error("condition on a non-Bcc beat");

  // Indexed modes report only the opcode word.
  a_idx_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_ext_follows_o |->
      length_bytes_o == 3'd2 &&
      (ea_mode_o == cfd_pkg::MODE_D8ANXN || ea_mode_o == cfd_pkg::MODE_PCD8XN))
    else $error("indexed flag with wrong mode or length");

  // A beat accepted into an empty pipeline is registered in the first stage.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !s1_valid && !s2_valid && !out_valid_o |=>
      s1_valid)
    else $error("accepted beat lost in first stage");
`endif

endmodule

FILE: rtl/cfd_classify.sv
// First pipeline stage: classifies the opcode word and registers it with its extension words.
module cfd_classify (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       opcode_word_i,
  input  logic [15:0]       ext_word_one_i,
  input  logic [15:0]       ext_word_two_i,
  input  logic [1:0]        words_available_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfd_pkg::class_t   cls_o,
  output logic [7:0]        imm8_o,
  output logic [15:0]       ext_one_o,
  output logic [15:0]       ext_two_o,
  output logic [1:0]        avail_o
);

  logic              valid_q;
  cfd_pkg::class_t   cls_d, cls_q;
  logic [7:0]        imm8_q;
  logic [15:0]       ext_one_q, ext_two_q;
  logic [1:0]        avail_q;
  logic [15:0]       masked;
  logic [3:0]        cond;
  cfd_pkg::kind_e    jk;
  logic              load;

  assign masked = opcode_word_i & cfd_pkg::OP_REG_MASK;
  assign cond   = opcode_word_i[11:8];
  assign jk     = opcode_word_i[6] ? cfd_pkg::KIND_JMP : cfd_pkg::KIND_JSR;

  always_comb begin
    cls_d          = '0;
    cls_d.kind     = cfd_pkg::KIND_NONE;
    cls_d.mode     = cfd_pkg::MODE_NONE;
    cls_d.sel      = cfd_pkg::DISP_ZERO;
    cls_d.need     = 2'd0;
    if (opcode_word_i == cfd_pkg::OP_RTS) begin
      cls_d.kind = cfd_pkg::KIND_RTS;
      cls_d.len  = 3'd2;
    end else if (masked == cfd_pkg::OP_JSR_AN || masked == cfd_pkg::OP_JMP_AN) begin
      cls_d.kind     = jk;
      cls_d.mode     = cfd_pkg::MODE_AN;
      cls_d.addr_reg = opcode_word_i[2:0];
      cls_d.len      = 3'd2;
    end else if (masked == cfd_pkg::OP_JSR_D16 || masked == cfd_pkg::OP_JMP_D16) begin
      cls_d.kind     = jk;
      cls_d.mode     = cfd_pkg::MODE_D16AN;
      cls_d.addr_reg = opcode_word_i[2:0];
      cls_d.sel      = cfd_pkg::DISP_SEXT16;
      cls_d.len      = 3'd4;
      cls_d.need     = 2'd2;
    end else if (opcode_word_i == cfd_pkg::OP_JSR_PCD16 ||
                 opcode_word_i == cfd_pkg::OP_JMP_PCD16) begin
      cls_d.kind = jk;
      cls_d.mode = cfd_pkg::MODE_PCD16;
      cls_d.sel  = cfd_pkg::DISP_SEXT16;
      cls_d.len  = 3'd4;
      cls_d.need = 2'd2;
    end else if (masked == cfd_pkg::OP_JSR_IDX || masked == cfd_pkg::OP_JMP_IDX ||
                 opcode_word_i == cfd_pkg::OP_JSR_PCIDX ||
                 opcode_word_i == cfd_pkg::OP_JMP_PCIDX) begin
      cls_d.kind = jk;
      cls_d.len  = 3'd2;
      cls_d.idx  = 1'b1;
      cls_d.need = 2'd2;
      if (opcode_word_i == cfd_pkg::OP_JSR_PCIDX ||
          opcode_word_i == cfd_pkg::OP_JMP_PCIDX) begin
        cls_d.mode = cfd_pkg::MODE_PCD8XN;
      end else begin
        cls_d.mode     = cfd_pkg::MODE_D8ANXN;
        cls_d.addr_reg = opcode_word_i[2:0];
      end
    end else if (opcode_word_i == cfd_pkg::OP_JSR_ABSW ||
                 opcode_word_i == cfd_pkg::OP_JMP_ABSW) begin
      cls_d.kind = jk;
      cls_d.mode = cfd_pkg::MODE_ABSW;
      cls_d.sel  = cfd_pkg::DISP_SEXT16;
      cls_d.len  = 3'd4;
      cls_d.need = 2'd2;
    end else if (opcode_word_i == cfd_pkg::OP_JSR_ABSL ||
                 opcode_word_i == cfd_pkg::OP_JMP_ABSL) begin
      cls_d.kind = jk;
      cls_d.mode = cfd_pkg::MODE_ABSL;
      cls_d.sel  = cfd_pkg::DISP_ABS32;
      cls_d.len  = 3'd6;
      cls_d.need = 2'd3;
    end else if (opcode_word_i[15:12] == cfd_pkg::OP_BRANCH_HI) begin
      if (opcode_word_i[7:0] != 8'h00) begin
        // Only the short subroutine branch is taken; other short branches stay unknown.
        if (cond == cfd_pkg::COND_BSR) begin
          cls_d.kind = cfd_pkg::KIND_BSR;
          cls_d.sel  = cfd_pkg::DISP_SEXT8;
          cls_d.len  = 3'd2;
        end
      end else begin
        cls_d.need = 2'd2;
        cls_d.sel  = cfd_pkg::DISP_SEXT16;
        cls_d.len  = 3'd4;
        if (cond == cfd_pkg::COND_BSR) begin
          cls_d.kind = cfd_pkg::KIND_BSR;
        end else begin
          cls_d.kind    = (cond == cfd_pkg::COND_ALWAYS) ? cfd_pkg::KIND_BRA
                                                         : cfd_pkg::KIND_BCC;
          cls_d.cond    = cond;
          cls_d.adv     = 2'd2;
          cls_d.sub_two = 1'b1;
        end
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cls_q     <= cls_d;
      imm8_q    <= opcode_word_i[7:0];
      ext_one_q <= ext_word_one_i;
      ext_two_q <= ext_word_two_i;
      avail_q   <= words_available_i;
    end
  end

  assign out_valid_o = valid_q;
  assign cls_o       = cls_q;
  assign imm8_o      = imm8_q;
  assign ext_one_o   = ext_one_q;
  assign ext_two_o   = ext_two_q;
  assign avail_o     = avail_q;

endmodule

FILE: rtl/cfd_operand.sv
// Second pipeline stage: checks the word count and forms the raw displacement.
module cfd_operand (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cfd_pkg::class_t   cls_i,
  input  logic [7:0]        imm8_i,
  input  logic [15:0]       ext_one_i,
  input  logic [15:0]       ext_two_i,
  input  logic [1:0]        avail_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfd_pkg::res_t     res_o,
  output logic [31:0]       disp_o,
  output logic              sub_two_o
);

  logic            valid_q;
  logic            ok;
  cfd_pkg::res_t   res_d, res_q;
  logic [31:0]     disp_d, disp_q;
  logic            sub_two_d, sub_two_q;
  logic            load;

  // A count of zero fails every need for an extension word, just as a count of one does.
  assign ok = (avail_i >= cls_i.need) && (cls_i.kind != cfd_pkg::KIND_NONE);

  always_comb begin
    case (cls_i.sel)
      cfd_pkg::DISP_SEXT8:  disp_d = {{24{imm8_i[7]}}, imm8_i};
      cfd_pkg::DISP_SEXT16: disp_d = {{16{ext_one_i[15]}}, ext_one_i};
      cfd_pkg::DISP_ABS32:  disp_d = {ext_one_i, ext_two_i};
      default:              disp_d = 32'd0;
    endcase
    res_d.kind     = cls_i.kind;
    res_d.mode     = cls_i.mode;
    res_d.addr_reg = cls_i.addr_reg;
    res_d.cond     = cls_i.cond;
    res_d.len      = cls_i.len;
    res_d.adv      = cls_i.adv;
    res_d.idx      = cls_i.idx;
    sub_two_d      = cls_i.sub_two;
    if (!ok) begin
      res_d      = '0;
      res_d.kind = cfd_pkg::KIND_NONE;
      res_d.mode = cfd_pkg::MODE_NONE;
      disp_d     = 32'd0;
      sub_two_d  = 1'b0;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q     <= res_d;
      disp_q    <= disp_d;
      sub_two_q <= sub_two_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
  assign disp_o      = disp_q;
  assign sub_two_o   = sub_two_q;

endmodule

FILE: rtl/cfd_adjust.sv
// Third pipeline stage: applies the word branch offset and holds the result register.
module cfd_adjust (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cfd_pkg::res_t     res_i,
  input  logic [31:0]       disp_i,
  input  logic              sub_two_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfd_pkg::res_t     res_o,
  output logic [31:0]       disp_o
);

  logic            valid_q;
  cfd_pkg::res_t   res_q;
  logic [31:0]     disp_d, disp_q;
  logic            load;

  // Word BRA and Bcc branches are relative to the extension word, two bytes past the opcode.
  assign disp_d = sub_two_i ? (disp_i - 32'd2) : disp_i;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q  <= res_i;
      disp_q <= disp_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;
  assign disp_o      = disp_q;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the control-flow instruction decoder unit.
`timescale 1ns / 1ps

module tb_top;

  // One fetch group offered to the decoder.
  typedef struct {
    logic [15:0] op;
    logic [15:0] e1;
    logic [15:0] e2;
    logic [1:0]  avail;
  } fetch_t;

  // One decoded control-flow record.
  typedef struct {
    cfd_pkg::kind_e     kind;
    cfd_pkg::mode_e     mode;
    logic [2:0]         areg;
    logic signed [31:0] disp;
    logic [3:0]         cond;
    logic [2:0]         len;
    logic [1:0]         adv;
    logic               idx;
  } decode_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [15:0]        opcode_word_i;
  logic [15:0]        ext_word_one_i;
  logic [15:0]        ext_word_two_i;
  logic [1:0]         words_available_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         kind_o;
  logic [2:0]         ea_mode_o;
  logic [2:0]         addr_reg_o;
  logic signed [31:0] displacement_o;
  logic [3:0]         cond_code_o;
  logic [2:0]         length_bytes_o;
  logic [1:0]         pc_advance_o;
  logic               index_ext_follows_o;

  fetch_t  pending_fetches[$];
  decode_t expected_decodes[$];
  decode_t want;
  fetch_t  next_fetch;
  logic    in_taken;
  int      sent_count;
  int      checked_count;
  int      unrecognized_count;
  int      mismatches;

  control_flow_instruction_decoder_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_word_i       (opcode_word_i),
    .ext_word_one_i      (ext_word_one_i),
    .ext_word_two_i      (ext_word_two_i),
    .words_available_i   (words_available_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .kind_o              (kind_o),
    .ea_mode_o           (ea_mode_o),
    .addr_reg_o          (addr_reg_o),
    .displacement_o      (displacement_o),
    .cond_code_o         (cond_code_o),
    .length_bytes_o      (length_bytes_o),
    .pc_advance_o        (pc_advance_o),
    .index_ext_follows_o (index_ext_follows_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic decode_t predict_decode(logic [15:0] w, logic [15:0] e1,
                                             logic [15:0] e2, logic [1:0] avail);
    decode_t        d;
    logic [15:0]    masked;
    cfd_pkg::kind_e jk;
    logic [31:0]    s16;
    logic [3:0]     c;
    d.kind = cfd_pkg::KIND_NONE;
    d.mode = cfd_pkg::MODE_NONE;
    d.areg = '0;
    d.disp = '0;
    d.cond = '0;
    d.len  = '0;
    d.adv  = '0;
    d.idx  = 1'b0;
    masked = w & cfd_pkg::OP_REG_MASK;
    jk     = w[6] ? cfd_pkg::KIND_JMP : cfd_pkg::KIND_JSR;
    s16    = {{16{e1[15]}}, e1};
    c      = w[11:8];
    if (w == cfd_pkg::OP_RTS) begin
      d.kind = cfd_pkg::KIND_RTS;
      d.len  = 3'd2;
    end else if (masked == cfd_pkg::OP_JSR_AN || masked == cfd_pkg::OP_JMP_AN) begin
      d.kind = jk;
      d.mode = cfd_pkg::MODE_AN;
      d.areg = w[2:0];
      d.len  = 3'd2;
    end else if (masked == cfd_pkg::OP_JSR_D16 || masked == cfd_pkg::OP_JMP_D16) begin
      if (avail >= 2'd2) begin
        d.kind = jk;
        d.mode = cfd_pkg::MODE_D16AN;
        d.areg = w[2:0];
        d.disp = s16;
        d.len  = 3'd4;
      end
    end else if (w == cfd_pkg::OP_JSR_PCD16 || w == cfd_pkg::OP_JMP_PCD16) begin
      if (avail >= 2'd2) begin
        d.kind = jk;
        d.mode = cfd_pkg::MODE_PCD16;
        d.disp = s16;
        d.len  = 3'd4;
      end
    end else if (masked == cfd_pkg::OP_JSR_IDX || masked == cfd_pkg::OP_JMP_IDX ||
                 w == cfd_pkg::OP_JSR_PCIDX || w == cfd_pkg::OP_JMP_PCIDX) begin
      if (avail >= 2'd2) begin
        d.kind = jk;
        d.len  = 3'd2;
        d.idx  = 1'b1;
        if (w == cfd_pkg::OP_JSR_PCIDX || w == cfd_pkg::OP_JMP_PCIDX) begin
          d.mode = cfd_pkg::MODE_PCD8XN;
        end else begin
          d.mode = cfd_pkg::MODE_D8ANXN;
          d.areg = w[2:0];
        end
      end
    end else if (w == cfd_pkg::OP_JSR_ABSW || w == cfd_pkg::OP_JMP_ABSW) begin
      if (avail >= 2'd2) begin
        d.kind = jk;
        d.mode = cfd_pkg::MODE_ABSW;
        d.disp = s16;
        d.len  = 3'd4;
      end
    end else if (w == cfd_pkg::OP_JSR_ABSL || w == cfd_pkg::OP_JMP_ABSL) begin
      if (avail == 2'd3) begin
        d.kind = jk;
        d.mode = cfd_pkg::MODE_ABSL;
        d.disp = {e1, e2};
        d.len  = 3'd6;
      end
    end else if (w[15:12] == cfd_pkg::OP_BRANCH_HI) begin
      if (w[7:0] != 8'd0) begin
        // Only the short subroutine branch is decoded; other short branches are dropped.
        if (c == cfd_pkg::COND_BSR) begin
          d.kind = cfd_pkg::KIND_BSR;
          d.disp = {{24{w[7]}}, w[7:0]};
          d.len  = 3'd2;
        end
      end else if (avail >= 2'd2) begin
        if (c == cfd_pkg::COND_BSR) begin
          d.kind = cfd_pkg::KIND_BSR;
          d.disp = s16;
          d.len  = 3'd4;
        end else begin
          d.kind = (c == cfd_pkg::COND_ALWAYS) ? cfd_pkg::KIND_BRA : cfd_pkg::KIND_BCC;
          d.cond = c;
          d.disp = s16 - 32'd2;
          d.len  = 3'd4;
          d.adv  = 2'd2;
        end
      end
    end
    return d;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h",
               $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic add_fetch(logic [15:0] op, logic [15:0] e1, logic [15:0] e2,
                           logic [1:0] avail);
    fetch_t f;
    f.op    = op;
    f.e1    = e1;
    f.e2    = e2;
    f.avail = avail;
    pending_fetches.push_back(f);
  endtask

  // Input driver: a new beat is offered only once the previous one was taken; out_ready_i is also driven here.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i        <= 1'b0;
      opcode_word_i     <= '0;
      ext_word_one_i    <= '0;
      ext_word_two_i    <= '0;
      words_available_i <= '0;
      out_ready_i       <= 1'b0;
    end else begin
      if (!in_valid_i || in_taken) begin
        if (pending_fetches.size() != 0 &&
            ((sent_count >= 350 && sent_count < 500) || $urandom_range(99) >= 29)) begin
          next_fetch = pending_fetches.pop_front();
          in_valid_i        <= 1'b1;
          opcode_word_i     <= next_fetch.op;
          ext_word_one_i    <= next_fetch.e1;
          ext_word_two_i    <= next_fetch.e2;
          words_available_i <= next_fetch.avail;
          sent_count++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= (checked_count >= 330 && checked_count < 520) ||
                     ($urandom_range(99) >= 29);
    end
  end

  // Monitor: checks each output beat, then records the prediction for an input beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (expected_decodes.size() == 0) begin
          $display("%0t: output beat with no decode pending: expected none, actual kind %0d",
                   $time, kind_o);
          mismatches++;
        end else begin
          want = expected_decodes.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_o));
          check_field("ea_mode", 32'(want.mode), 32'(ea_mode_o));
          check_field("addr_reg", 32'(want.areg), 32'(addr_reg_o));
          check_field("displacement", want.disp, displacement_o);
          check_field("cond_code", 32'(want.cond), 32'(cond_code_o));
          check_field("length_bytes", 32'(want.len), 32'(length_bytes_o));
          check_field("pc_advance", 32'(want.adv), 32'(pc_advance_o));
          check_field("index_ext_follows", 32'(want.idx), 32'(index_ext_follows_o));
          checked_count++;
          if (want.kind == cfd_pkg::KIND_NONE) unrecognized_count++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_decodes.push_back(predict_decode(opcode_word_i, ext_word_one_i,
                                                  ext_word_two_i, words_available_i));
      end
    end
  end

  initial begin
    logic [15:0] op;
    logic [15:0] e1;
    logic [15:0] e2;
    logic [1:0]  avail;
    logic [15:0] jmp_bit;
    sent_count         = 0;
    checked_count      = 0;
    unrecognized_count = 0;
    mismatches         = 0;

    // Directed part: each form, missing extension words, byte branches and field extremes.
    add_fetch(cfd_pkg::OP_RTS, 16'h0000, 16'h0000, 2'd1);
    add_fetch(cfd_pkg::OP_RTS, 16'hffff, 16'hffff, 2'd0);
    add_fetch(cfd_pkg::OP_JSR_AN | 16'd5, 16'h1234, 16'h0000, 2'd1);
    add_fetch(cfd_pkg::OP_JMP_AN | 16'd7, 16'h0000, 16'h0000, 2'd3);
    add_fetch(cfd_pkg::OP_JMP_AN | 16'd1, 16'h0000, 16'h0000, 2'd0);
    add_fetch(cfd_pkg::OP_JSR_D16 | 16'd2, 16'h8000, 16'h0000, 2'd2);
    add_fetch(cfd_pkg::OP_JMP_D16 | 16'd7, 16'h7fff, 16'h0000, 2'd1);
    add_fetch(cfd_pkg::OP_JSR_D16, 16'h7fff, 16'h0000, 2'd0);
    add_fetch(cfd_pkg::OP_JSR_PCD16, 16'h7fff, 16'hffff, 2'd3);
    add_fetch(cfd_pkg::OP_JMP_PCD16, 16'h8000, 16'h0000, 2'd1);
    add_fetch(cfd_pkg::OP_JSR_IDX | 16'd3, 16'hffff, 16'h0000, 2'd2);
    add_fetch(cfd_pkg::OP_JMP_PCIDX, 16'h0000, 16'h0000, 2'd3);
    add_fetch(cfd_pkg::OP_JMP_IDX, 16'h0000, 16'h0000, 2'd1);
    add_fetch(cfd_pkg::OP_JSR_ABSW, 16'hffff, 16'h0000, 2'd2);
    add_fetch(cfd_pkg::OP_JMP_ABSW, 16'h0001, 16'h0000, 2'd3);
    add_fetch(cfd_pkg::OP_JSR_ABSL, 16'hffff, 16'h0000, 2'd3);
    add_fetch(cfd_pkg::OP_JMP_ABSL, 16'h8000, 16'hffff, 2'd2);
    add_fetch(16'h6000, 16'h0000, 16'h0000, 2'd2);
    add_fetch(16'h6000, 16'h8000, 16'h0000, 2'd3);
    add_fetch(16'h6f00, 16'h0001, 16'h0000, 2'd2);
    add_fetch(16'h6100, 16'h7fff, 16'h0000, 2'd2);
    add_fetch(16'h6200, 16'h0002, 16'h0000, 2'd1);
    add_fetch(16'h61ff, 16'h0000, 16'h0000, 2'd1);
    add_fetch(16'h6180, 16'h0000, 16'h0000, 2'd0);
    add_fetch(16'h6001, 16'h0000, 16'h0000, 2'd3);
    add_fetch(16'h67fe, 16'h1111, 16'h0000, 2'd3);
    add_fetch(16'h0000, 16'h0000, 16'h0000, 2'd0);
    add_fetch(16'hffff, 16'hffff, 16'hffff, 2'd3);

    // Random part: mostly well-formed control-flow words, the rest near misses and noise.
    repeat (900) begin
      e1      = 16'($urandom);
      e2      = 16'($urandom);
      jmp_bit = $urandom_range(1) ? 16'h0040 : 16'h0000;
      avail   = ($urandom_range(9) < 7) ? 2'd3 : 2'($urandom_range(3));
      case ($urandom_range(13))
        0:  op = cfd_pkg::OP_RTS;
        1:  op = cfd_pkg::OP_JSR_AN | jmp_bit | 16'($urandom_range(7));
        2:  op = cfd_pkg::OP_JSR_D16 | jmp_bit | 16'($urandom_range(7));
        3:  op = cfd_pkg::OP_JSR_PCD16 | jmp_bit;
        4:  op = cfd_pkg::OP_JSR_IDX | jmp_bit | 16'($urandom_range(7));
        5:  op = cfd_pkg::OP_JSR_PCIDX | jmp_bit;
        6:  op = cfd_pkg::OP_JSR_ABSW | jmp_bit;
        7:  op = cfd_pkg::OP_JSR_ABSL | jmp_bit;
        8:  op = {cfd_pkg::OP_BRANCH_HI, 4'($urandom_range(15)), 8'h00};
        9:  op = {cfd_pkg::OP_BRANCH_HI, 4'($urandom_range(15)), 8'h00};
        10: op = {cfd_pkg::OP_BRANCH_HI,
                  ($urandom_range(1) ? cfd_pkg::COND_BSR : 4'($urandom_range(15))),
                  8'($urandom_range(1, 255))};
        11: op = {8'h4e, 8'($urandom)};
        default: op = 16'($urandom);
      endcase
      add_fetch(op, e1, e2, avail);
    end

    while (pending_fetches.size() != 0 || in_valid_i || expected_decodes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    $display("Checked %0d decode results from %0d fetch groups, %0d of them not recognized.",
             checked_count, sent_count, unrecognized_count);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d decodes still expected.", expected_decodes.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
